### rtl/smp_pkg.sv
package smp_pkg;

    localparam int SAMPLES_PER_AVERAGE = 350;
    localparam int EASE_STEPS = 181;
    localparam int EASE_LAST = EASE_STEPS - 1;
    localparam int EASE_HALF = EASE_LAST / 2;
    localparam int PULSE_MAX = 32767;

    localparam int NUM_W = 40;
    localparam int DEN_W = 32;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * 4095 + 1);
    localparam int TALLY_W = $clog2(SAMPLES_PER_AVERAGE + 1);

    localparam logic [1:0] MODE_GOAL = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] KIND_LINEAR = 3'd2;
    localparam logic [2:0] KIND_COSINE = 3'd3;
    localparam logic [2:0] KIND_SQCOS = 3'd4;

    localparam logic [2:0] REG_ANGLE_LOW = 3'd0;
    localparam logic [2:0] REG_ANGLE_HIGH = 3'd1;
    localparam logic [2:0] REG_PULSE_LOW = 3'd2;
    localparam logic [2:0] REG_PULSE_HIGH = 3'd3;
    localparam logic [2:0] REG_SENSOR_LOW = 3'd4;
    localparam logic [2:0] REG_SENSOR_HIGH = 3'd5;
    localparam logic [2:0] REG_PROFILE = 3'd6;
    localparam logic [2:0] REG_SLEW = 3'd7;

    localparam logic [6:0] COS_HALF [0:EASE_HALF] = '{
        7'd100, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd98, 7'd98,
        7'd98, 7'd97, 7'd97, 7'd97, 7'd96, 7'd96, 7'd95, 7'd95, 7'd94, 7'd93, 7'd93,
        7'd92, 7'd92, 7'd91, 7'd90, 7'd89, 7'd89, 7'd88, 7'd87, 7'd86, 7'd85, 7'd84,
        7'd83, 7'd82, 7'd81, 7'd80, 7'd79, 7'd78, 7'd77, 7'd76, 7'd75, 7'd74, 7'd73,
        7'd71, 7'd70, 7'd69, 7'd68, 7'd66, 7'd65, 7'd64, 7'd62, 7'd61, 7'd60, 7'd58,
        7'd57, 7'd55, 7'd54, 7'd52, 7'd51, 7'd50, 7'd48, 7'd46, 7'd45, 7'd43, 7'd42,
        7'd40, 7'd39, 7'd37, 7'd35, 7'd34, 7'd32, 7'd30, 7'd29, 7'd27, 7'd25, 7'd24,
        7'd22, 7'd20, 7'd19, 7'd17, 7'd15, 7'd13, 7'd12, 7'd10, 7'd8, 7'd6, 7'd5,
        7'd3, 7'd1, 7'd0
    };

    localparam logic [6:0] SQCOS_HALF [0:EASE_HALF] = '{
        7'd100, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
        7'd99, 7'd98, 7'd98, 7'd98, 7'd98, 7'd98, 7'd97, 7'd97, 7'd97, 7'd96, 7'd96,
        7'd96, 7'd95, 7'd95, 7'd95, 7'd94, 7'd94, 7'd93, 7'd93, 7'd93, 7'd92, 7'd92,
        7'd91, 7'd91, 7'd90, 7'd89, 7'd89, 7'd88, 7'd88, 7'd87, 7'd86, 7'd86, 7'd85,
        7'd84, 7'd84, 7'd83, 7'd82, 7'd81, 7'd80, 7'd80, 7'd79, 7'd78, 7'd77, 7'd76,
        7'd75, 7'd74, 7'd73, 7'd72, 7'd71, 7'd70, 7'd69, 7'd68, 7'd67, 7'd66, 7'd65,
        7'd63, 7'd62, 7'd61, 7'd59, 7'd58, 7'd57, 7'd55, 7'd54, 7'd52, 7'd50, 7'd49,
        7'd47, 7'd45, 7'd43, 7'd41, 7'd39, 7'd37, 7'd34, 7'd32, 7'd29, 7'd26, 7'd22,
        7'd18, 7'd13, 7'd0
    };

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [6:0] ease_half(input logic use_sqrt, input logic [6:0] idx);
        logic [6:0] v;
        v = use_sqrt ? SQCOS_HALF[idx] : COS_HALF[idx];
        return v;
    endfunction

endpackage

### rtl/smp_divider.sv
module smp_divider
    import smp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign fits = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.num;
            rem_reg  <= '0;
            den_reg  <= req.den;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? DEN_W'(shifted - {1'b0, den_reg}) : shifted[DEN_W-1:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### rtl/servo_motion_profile.sv
// a sample needs one divider pass only when it completes an average; a tick needs up to two passes
// a goal needs up to three passes through the 40-bit radix-2 divider
// one item at a time: the next item is accepted once the sequencer returns to idle
// the output register lets a new item start while the previous result waits
// reset: asynchronous active low, configuration registers take their defaults, motion state is zero
module servo_motion_profile
    import smp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [19:0] goal_angle,
    input  logic [11:0]        sensor_sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        pulse_us,
    output logic               moving,
    output logic [11:0]        position_avg
);

    typedef enum logic [3:0] {
        S_IDLE, S_GOAL_TGT, S_GOAL_ORG, S_GOAL_LEN, S_TICK,
        S_MUL, S_LCMP, S_DIV, S_DWAIT, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_TGT, OP_ORG, OP_LEN, OP_AVG, OP_LIN, OP_ARC, OP_EASE
    } op_t;

    state_t state_reg;
    op_t    op_reg;

    logic signed [19:0] al_reg, ah_reg;
    logic [14:0]        pl_reg, ph_reg;
    logic [11:0]        sl_reg, sh_reg;
    logic [2:0]         kind_reg;
    logic [15:0]        slew_reg;

    logic [14:0]        target_reg, origin_reg, present_reg;
    logic [31:0]        len_reg, elapsed_reg;
    logic               motion_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [11:0]        position_reg;

    logic signed [19:0] goal_reg;
    logic [31:0]        mul_a_reg;
    logic [15:0]        mul_b_reg;
    logic [47:0]        prod_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg_reg;

    logic               out_valid_reg;
    logic [14:0]        pulse_out_reg;
    logic               moving_out_reg;
    logic [11:0]        pos_out_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [19:0] ang_lo, ang_hi, ang_c;
    logic signed [20:0] da, dal;
    logic signed [15:0] dpl;
    logic signed [12:0] dx, dsl;
    logic [20:0]        da_mag, dal_mag;
    logic [15:0]        dpl_mag;
    logic [12:0]        dx_mag, dsl_mag;
    logic [14:0]        p_lo, p_hi;
    logic [15:0]        rate_now;
    logic               up;
    logic [14:0]        span;
    logic signed [41:0] q_signed, mapped;
    logic [14:0]        tgt_clamped, org_clamped;
    logic [14:0]        off;
    logic [14:0]        stepped;
    logic [SUM_W-1:0]   sum_next;
    logic [TALLY_W-1:0] tally_next;
    logic [7:0]         arc;
    logic [6:0]         arc_idx;
    logic [6:0]         ease_v;
    logic [7:0]         ease_weight;
    logic [24:0]        span_scaled;
    logic               eased;

    smp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign div_req.start = (state_reg == S_DIV);
    assign div_req.num   = prod_reg[NUM_W-1:0];
    assign div_req.den   = den_reg;

    always_comb
    begin
        ang_lo  = (al_reg < ah_reg) ? al_reg : ah_reg;
        ang_hi  = (al_reg < ah_reg) ? ah_reg : al_reg;
        ang_c   = (goal_reg < ang_lo) ? ang_lo : ((goal_reg > ang_hi) ? ang_hi : goal_reg);
        da      = {ang_c[19], ang_c} - {al_reg[19], al_reg};
        dal     = {ah_reg[19], ah_reg} - {al_reg[19], al_reg};
        dpl     = {1'b0, ph_reg} - {1'b0, pl_reg};
        dx      = {1'b0, position_reg} - {1'b0, sl_reg};
        dsl     = {1'b0, sh_reg} - {1'b0, sl_reg};
        da_mag  = da[20] ? 21'(21'd0 - da) : da;
        dal_mag = dal[20] ? 21'(21'd0 - dal) : dal;
        dpl_mag = dpl[15] ? 16'(16'd0 - dpl) : dpl;
        dx_mag  = dx[12] ? 13'(13'd0 - dx) : dx;
        dsl_mag = dsl[12] ? 13'(13'd0 - dsl) : dsl;
        p_lo    = (pl_reg < ph_reg) ? pl_reg : ph_reg;
        p_hi    = (pl_reg < ph_reg) ? ph_reg : pl_reg;
        rate_now = (slew_reg == 16'd0) ? 16'd1 : slew_reg;

        up   = target_reg > origin_reg;
        span = up ? 15'(target_reg - origin_reg) : 15'(origin_reg - target_reg);
        span_scaled = 25'(span) * 25'd1000;

        q_signed = $signed({2'b00, div_rsp.quot});
        mapped   = $signed({27'd0, pl_reg}) + (neg_reg ? -q_signed : q_signed);
        if (mapped < $signed({27'd0, p_lo}))
            tgt_clamped = p_lo;
        else if (mapped > $signed({27'd0, p_hi}))
            tgt_clamped = p_hi;
        else
            tgt_clamped = mapped[14:0];
        if (mapped < 42'sd0)
            org_clamped = 15'd0;
        else if (mapped > 42'sd32767)
            org_clamped = 15'(PULSE_MAX);
        else
            org_clamped = mapped[14:0];

        off     = div_rsp.quot[14:0];
        stepped = up ? 15'(origin_reg + off) : 15'(origin_reg - off);

        arc         = div_rsp.quot[7:0];
        arc_idx     = (arc <= 8'(EASE_HALF)) ? arc[6:0] : 7'(8'(EASE_LAST) - arc);
        ease_v      = ease_half(kind_reg == KIND_SQCOS, arc_idx);
        ease_weight = (arc <= 8'(EASE_HALF)) ? 8'(8'd100 - {1'b0, ease_v})
                                             : 8'(8'd100 + {1'b0, ease_v});

        eased      = (kind_reg == KIND_COSINE) || (kind_reg == KIND_SQCOS);
        sum_next   = sum_reg + SUM_W'(sensor_sample);
        tally_next = tally_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_TGT;
            al_reg        <= 20'sd0;
            ah_reg        <= 20'sd180000;
            pl_reg        <= 15'd1000;
            ph_reg        <= 15'd2000;
            sl_reg        <= 12'd0;
            sh_reg        <= 12'd4095;
            kind_reg      <= 3'd0;
            slew_reg      <= 16'd1000;
            target_reg    <= '0;
            origin_reg    <= '0;
            present_reg   <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            motion_reg    <= 1'b0;
            sum_reg       <= '0;
            tally_reg     <= '0;
            position_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ANGLE_LOW:   al_reg   <= cfg_data;
                    REG_ANGLE_HIGH:  ah_reg   <= cfg_data;
                    REG_PULSE_LOW:   pl_reg   <= cfg_data[14:0];
                    REG_PULSE_HIGH:  ph_reg   <= cfg_data[14:0];
                    REG_SENSOR_LOW:  sl_reg   <= cfg_data[11:0];
                    REG_SENSOR_HIGH: sh_reg   <= cfg_data[11:0];
                    REG_PROFILE:     kind_reg <= cfg_data[2:0];
                    REG_SLEW:        slew_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        goal_reg <= goal_angle;
                        unique case (mode)
                            MODE_GOAL:
                                state_reg <= S_GOAL_TGT;
                            MODE_SAMPLE:
                            begin
                                if (tally_next >= TALLY_W'(SAMPLES_PER_AVERAGE))
                                begin
                                    prod_reg  <= 48'(sum_next);
                                    den_reg   <= DEN_W'(SAMPLES_PER_AVERAGE);
                                    op_reg    <= OP_AVG;
                                    state_reg <= S_DIV;
                                end
                                else
                                    state_reg <= S_FIN;
                                sum_reg   <= sum_next;
                                tally_reg <= tally_next;
                            end
                            MODE_TICK:
                            begin
                                if (elapsed_reg != 32'hFFFF_FFFF)
                                    elapsed_reg <= elapsed_reg + 1'b1;
                                state_reg <= S_TICK;
                            end
                            default:
                                state_reg <= S_FIN;
                        endcase
                    end
                end
                S_GOAL_TGT:
                begin
                    if (al_reg == ah_reg)
                    begin
                        target_reg <= pl_reg;
                        state_reg  <= S_GOAL_ORG;
                    end
                    else
                    begin
                        mul_a_reg <= 32'(da_mag);
                        mul_b_reg <= dpl_mag;
                        den_reg   <= DEN_W'(dal_mag);
                        neg_reg   <= da[20] ^ dpl[15] ^ dal[20];
                        op_reg    <= OP_TGT;
                        state_reg <= S_MUL;
                    end
                end
                S_GOAL_ORG:
                begin
                    if (sl_reg == sh_reg)
                    begin
                        origin_reg <= pl_reg;
                        state_reg  <= S_GOAL_LEN;
                    end
                    else
                    begin
                        mul_a_reg <= 32'(dx_mag);
                        mul_b_reg <= dpl_mag;
                        den_reg   <= DEN_W'(dsl_mag);
                        neg_reg   <= dx[12] ^ dpl[15] ^ dsl[12];
                        op_reg    <= OP_ORG;
                        state_reg <= S_MUL;
                    end
                end
                S_GOAL_LEN:
                begin
                    mul_a_reg <= 32'(span);
                    mul_b_reg <= 16'd1000;
                    den_reg   <= DEN_W'(rate_now);
                    op_reg    <= OP_LEN;
                    state_reg <= S_MUL;
                end
                S_TICK:
                begin
                    if (kind_reg == KIND_LINEAR)
                    begin
                        if (span == 15'd0)
                        begin
                            motion_reg <= 1'b0;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            mul_a_reg <= elapsed_reg;
                            mul_b_reg <= rate_now;
                            op_reg    <= OP_LIN;
                            state_reg <= S_MUL;
                        end
                    end
                    else if (eased)
                    begin
                        if (span == 15'd0)
                        begin
                            motion_reg <= 1'b0;
                            state_reg  <= S_FIN;
                        end
                        else if ((len_reg == 32'd0) || (elapsed_reg >= len_reg))
                        begin
                            present_reg <= target_reg;
                            motion_reg  <= 1'b0;
                            state_reg   <= S_FIN;
                        end
                        else
                        begin
                            mul_a_reg <= elapsed_reg;
                            mul_b_reg <= 16'd180;
                            den_reg   <= len_reg;
                            op_reg    <= OP_ARC;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        present_reg <= target_reg;
                        motion_reg  <= 1'b0;
                        state_reg   <= S_FIN;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= mul_a_reg * mul_b_reg;
                    state_reg <= (op_reg == OP_LIN) ? S_LCMP : S_DIV;
                end
                S_LCMP:
                begin
                    if (prod_reg >= 48'(span_scaled))
                    begin
                        present_reg <= target_reg;
                        motion_reg  <= 1'b0;
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        den_reg   <= DEN_W'(1000);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        unique case (op_reg)
                            OP_TGT:
                            begin
                                target_reg <= tgt_clamped;
                                state_reg  <= S_GOAL_ORG;
                            end
                            OP_ORG:
                            begin
                                origin_reg <= org_clamped;
                                state_reg  <= S_GOAL_LEN;
                            end
                            OP_LEN:
                            begin
                                len_reg     <= div_rsp.quot[31:0];
                                elapsed_reg <= '0;
                                motion_reg  <= 1'b1;
                                state_reg   <= S_FIN;
                            end
                            OP_AVG:
                            begin
                                position_reg <= div_rsp.quot[11:0];
                                sum_reg      <= '0;
                                tally_reg    <= '0;
                                state_reg    <= S_FIN;
                            end
                            OP_LIN:
                            begin
                                present_reg <= stepped;
                                state_reg   <= S_FIN;
                            end
                            OP_ARC:
                            begin
                                mul_a_reg <= 32'(ease_weight);
                                mul_b_reg <= 16'(span);
                                den_reg   <= DEN_W'(200);
                                op_reg    <= OP_EASE;
                                state_reg <= S_MUL;
                            end
                            OP_EASE:
                            begin
                                present_reg <= stepped;
                                state_reg   <= S_FIN;
                            end
                            default:
                                state_reg <= S_FIN;
                        endcase
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        pulse_out_reg  <= present_reg;
                        moving_out_reg <= motion_reg;
                        pos_out_reg    <= position_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign pulse_us     = pulse_out_reg;
    assign moving       = moving_out_reg;
    assign position_avg = pos_out_reg;

`ifndef SYNTH
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DWAIT))
        else $error("divider result with no waiting step");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken during work");
`endif

endmodule

### test/testbench.sv
module testbench;
    import smp_pkg::*;

    typedef struct {
        logic [1:0]         md;
        logic signed [19:0] angle;
        logic [11:0]        sample;
    } servo_item_t;

    typedef struct {
        logic [14:0] pulse;
        logic        mov;
        logic [11:0] avg;
    } servo_report_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [19:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic signed [19:0] goal_angle;
    logic [11:0]        sensor_sample;
    logic               out_valid;
    logic               out_ready;
    logic [14:0]        pulse_us;
    logic               moving;
    logic [11:0]        position_avg;

    servo_item_t   pending_items[$];
    servo_report_t servo_reports[$];
    servo_item_t   cur_item;
    logic          fire;
    int            gap_left;
    int            burst_left;
    int            hold_left;
    int            stretch_left;
    bit            choppy;
    bit            long_hold_done;
    int            errors;
    int            received;
    int            goals_sent;
    int            ticks_sent;
    int            samples_sent;
    int            phases_run;

    // configuration copy
    longint ang_lo, ang_hi, pul_lo, pul_hi, sen_lo, sen_hi;
    longint kind, rate;
    // motion copy
    longint tgt, org, pres;
    longint move_len, elapsed;
    bit     in_move;
    longint acc_sum, acc_count, avg_val;

    servo_motion_profile i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .goal_angle    (goal_angle),
        .sensor_sample (sensor_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pulse_us      (pulse_us),
        .moving        (moving),
        .position_avg  (position_avg)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint map_range(longint x, longint a, longint b, longint c, longint d);
        if (a == b)
            return c;
        return (x - a) * (d - c) / (b - a) + c;
    endfunction

    function automatic longint clamp_to(longint x, longint e1, longint e2);
        longint lo;
        longint hi;
        lo = (e1 < e2) ? e1 : e2;
        hi = (e1 < e2) ? e2 : e1;
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint ease_at(longint arc, bit use_sqrt);
        longint idx;
        idx = (arc > EASE_LAST) ? EASE_LAST : arc;
        if (idx <= EASE_HALF)
            return use_sqrt ? longint'(SQCOS_HALF[idx]) : longint'(COS_HALF[idx]);
        return use_sqrt ? -longint'(SQCOS_HALF[EASE_LAST - idx])
                        : -longint'(COS_HALF[EASE_LAST - idx]);
    endfunction

    task automatic advance_servo(input servo_item_t it, output servo_report_t rep);
        longint r;
        longint a;
        longint span;
        longint off;
        longint arc;
        bit     up;
        r = (rate == 0) ? 1 : rate;
        if (it.md == MODE_GOAL)
        begin
            a = clamp_to(longint'(it.angle), ang_lo, ang_hi);
            tgt = clamp_to(map_range(a, ang_lo, ang_hi, pul_lo, pul_hi), pul_lo, pul_hi);
            org = clamp_to(map_range(avg_val, sen_lo, sen_hi, pul_lo, pul_hi), 0, PULSE_MAX);
            span = (tgt > org) ? tgt - org : org - tgt;
            move_len = (span * 1000 / r) & 64'hFFFF_FFFF;
            elapsed = 0;
            in_move = 1'b1;
        end
        else if (it.md == MODE_SAMPLE)
        begin
            acc_sum += it.sample;
            acc_count++;
            if (acc_count >= SAMPLES_PER_AVERAGE)
            begin
                avg_val = (acc_sum / SAMPLES_PER_AVERAGE) & 12'hFFF;
                acc_sum = 0;
                acc_count = 0;
            end
        end
        else if (it.md == MODE_TICK)
        begin
            up = tgt > org;
            span = up ? tgt - org : org - tgt;
            if (elapsed != 64'hFFFF_FFFF)
                elapsed++;
            if (kind < KIND_LINEAR || kind > KIND_SQCOS)
            begin
                pres = tgt;
                in_move = 1'b0;
            end
            else if (span == 0)
                in_move = 1'b0;
            else
            begin
                if (kind == KIND_LINEAR)
                begin
                    off = r * elapsed / 1000;
                    if (off >= span)
                    begin
                        off = span;
                        in_move = 1'b0;
                    end
                end
                else
                begin
                    arc = (move_len == 0) ? EASE_LAST : elapsed * 180 / move_len;
                    if (arc >= EASE_LAST)
                    begin
                        arc = EASE_LAST;
                        in_move = 1'b0;
                    end
                    off = (100 - ease_at(arc, kind == KIND_SQCOS)) * span / 200;
                end
                pres = up ? org + off : org - off;
            end
        end
        rep.pulse = 15'(clamp_to(pres, 0, PULSE_MAX));
        rep.mov = in_move;
        rep.avg = 12'(avg_val);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        logic [19:0] raw;
        raw = val[19:0];
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= raw;
        case (idx)
            REG_ANGLE_LOW:   ang_lo = longint'($signed(raw));
            REG_ANGLE_HIGH:  ang_hi = longint'($signed(raw));
            REG_PULSE_LOW:   pul_lo = longint'(raw[14:0]);
            REG_PULSE_HIGH:  pul_hi = longint'(raw[14:0]);
            REG_SENSOR_LOW:  sen_lo = longint'(raw[11:0]);
            REG_SENSOR_HIGH: sen_hi = longint'(raw[11:0]);
            REG_PROFILE:     kind = longint'(raw[2:0]);
            REG_SLEW:        rate = longint'(raw[15:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        forever
        begin
            @(posedge clk);
            if (pending_items.size() == 0 && !in_valid && servo_reports.size() == 0)
                break;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic push_item(input logic [1:0] md, input longint angle, input longint sample);
        servo_item_t it;
        it.md = md;
        it.angle = angle[19:0];
        it.sample = sample[11:0];
        pending_items.push_back(it);
        if (md == MODE_GOAL)
            goals_sent++;
        else if (md == MODE_TICK)
            ticks_sent++;
        else if (md == MODE_SAMPLE)
            samples_sent++;
    endtask

    task automatic random_items(input int n);
        int pick;
        longint ang;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                if ($urandom_range(0, 3) == 0)
                    ang = longint'($signed(20'($urandom)));
                else
                    ang = longint'($urandom_range(0, 720000)) - 360000;
                push_item(MODE_GOAL, ang, $urandom);
            end
            else if (pick < 55)
                push_item(MODE_SAMPLE, $urandom, $urandom);
            else if (pick < 98)
                push_item(MODE_TICK, $urandom, $urandom);
            else
                push_item(MODE_UNUSED, $urandom, $urandom);
        end
    endtask

    task automatic random_config(input int k);
        write_reg(REG_ANGLE_LOW, longint'($urandom_range(0, 720000)) - 360000);
        write_reg(REG_ANGLE_HIGH, longint'($urandom_range(0, 720000)) - 360000);
        write_reg(REG_PULSE_LOW, $urandom_range(0, 32767));
        write_reg(REG_PULSE_HIGH, $urandom_range(0, 32767));
        write_reg(REG_SENSOR_LOW, $urandom_range(0, 4095));
        write_reg(REG_SENSOR_HIGH, $urandom_range(0, 4095));
        write_reg(REG_PROFILE, k);
        write_reg(REG_SLEW, $urandom_range(0, 65535));
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item = pending_items.pop_front();
                mode <= cur_item.md;
                goal_angle <= cur_item.angle;
                sensor_sample <= cur_item.sample;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!long_hold_done && received >= 700)
        begin
            long_hold_done = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(20, 400);
                choppy = $urandom_range(0, 1);
            end
            else
                stretch_left--;
            out_ready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // acceptance and checking
    always @(posedge clk)
    begin
        servo_report_t want;
        fire <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            advance_servo(cur_item, want);
            servo_reports.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            received++;
            if (servo_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item pulse %0d moving %0d avg %0d",
                         $time, pulse_us, moving, position_avg);
            end
            else
            begin
                want = servo_reports.pop_front();
                if (pulse_us !== want.pulse)
                begin
                    errors++;
                    $display("%0t: pulse_us expected %0d actual %0d", $time, want.pulse, pulse_us);
                end
                if (moving !== want.mov)
                begin
                    errors++;
                    $display("%0t: moving expected %0d actual %0d", $time, want.mov, moving);
                end
                if (position_avg !== want.avg)
                begin
                    errors++;
                    $display("%0t: position_avg expected %0d actual %0d",
                             $time, want.avg, position_avg);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = '0;
        goal_angle = '0;
        sensor_sample = '0;
        out_ready = 1'b0;
        fire = 1'b0;
        gap_left = 0;
        burst_left = 0;
        hold_left = 0;
        stretch_left = 0;
        choppy = 1'b0;
        long_hold_done = 1'b0;
        errors = 0;
        received = 0;
        ang_lo = 0;
        ang_hi = 180000;
        pul_lo = 1000;
        pul_hi = 2000;
        sen_lo = 0;
        sen_hi = 4095;
        kind = 0;
        rate = 1000;
        tgt = 0;
        org = 0;
        pres = 0;
        move_len = 0;
        elapsed = 0;
        in_move = 1'b0;
        acc_sum = 0;
        acc_count = 0;
        avg_val = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, angle extremes, undefined mode, sample extremes
        push_item(MODE_UNUSED, 0, 0);
        push_item(MODE_GOAL, -360000, 0);
        push_item(MODE_TICK, 0, 0);
        push_item(MODE_GOAL, 360000, 4095);
        push_item(MODE_TICK, 0, 4095);
        push_item(MODE_SAMPLE, 0, 4095);
        push_item(MODE_SAMPLE, 0, 0);
        push_item(MODE_GOAL, 90000, 0);
        push_item(MODE_TICK, 0, 0);
        push_item(MODE_UNUSED, -1, 4095);
        wait_idle();

        // eased and linear moves, then equal limits, zero rate, undefined kind
        for (int k = KIND_LINEAR; k <= KIND_SQCOS; k++)
        begin
            write_reg(REG_PROFILE, k);
            write_reg(REG_SLEW, (k == KIND_LINEAR) ? 65535 : 30000);
            push_item(MODE_GOAL, 0, 0);
            push_item(MODE_TICK, 0, 0);
            push_item(MODE_GOAL, 180000, 0);
            for (int j = 0; j < 4; j++)
                push_item(MODE_TICK, 0, 0);
            wait_idle();
        end
        write_reg(REG_ANGLE_LOW, 5000);
        write_reg(REG_ANGLE_HIGH, 5000);
        write_reg(REG_SENSOR_LOW, 4095);
        write_reg(REG_SENSOR_HIGH, 4095);
        write_reg(REG_PULSE_LOW, 32767);
        write_reg(REG_PULSE_HIGH, 0);
        write_reg(REG_SLEW, 0);
        write_reg(REG_PROFILE, 7);
        push_item(MODE_GOAL, 100, 0);
        push_item(MODE_TICK, 0, 0);
        wait_idle();
        write_reg(REG_PROFILE, KIND_SQCOS);
        push_item(MODE_GOAL, -100, 0);
        push_item(MODE_TICK, 0, 0);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            if (p == 0)
            begin
                write_reg(REG_ANGLE_LOW, -360000);
                write_reg(REG_ANGLE_HIGH, 360000);
                write_reg(REG_PULSE_LOW, 0);
                write_reg(REG_PULSE_HIGH, 32767);
                write_reg(REG_SENSOR_LOW, 0);
                write_reg(REG_SENSOR_HIGH, 4095);
                write_reg(REG_PROFILE, KIND_COSINE);
                write_reg(REG_SLEW, 65535);
            end
            else
                random_config((p < 8) ? (p % 5) : $urandom_range(0, 7));
            random_items(185);
            wait_idle();
            phases_run++;
        end

        $display("covered %0d goals, %0d ticks, %0d samples over %0d random settings",
                 goals_sent, ticks_sent, samples_sent, phases_run);
        $display("%0d items checked, every profile kind and limit extreme visited", received);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
